FILE: sv/pfla_pkg.sv
`timescale 1ns / 1ps

package pfla_pkg;

    // Field widths of the request and response ports
    localparam int PAGE_FIELD_W   = 10;
    localparam int COUNT_FIELD_W  = 11;

    // Default pool size
    localparam int PAGE_COUNT_DEF = 1024;

    // Request command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ALLOCATED = 2'd0,
        STATUS_FREED     = 2'd1,
        STATUS_IGNORED   = 2'd2,
        STATUS_EXHAUSTED = 2'd3
    } pfla_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } pfla_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // request transaction taken this cycle, memory read issued
        logic exec;     // read data valid, apply update and load response
    } pfla_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // response register empty or draining this cycle
    } pfla_sts_t;

endpackage

FILE: sv/pfla_ram.sv
`timescale 1ns / 1ps

module pfla_ram #(
    parameter int WIDTH = pfla_pkg::PAGE_FIELD_W + 1,
    parameter int DEPTH = pfla_pkg::PAGE_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import pfla_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

FILE: sv/pfla_ctrl.sv
`timescale 1ns / 1ps

module pfla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfla_pkg::pfla_sts_t sts,
    output pfla_pkg::pfla_cmd_t cmd
);
    import pfla_pkg::*;

    pfla_state_t state_reg;
    pfla_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.out_free)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = sts.out_free;
                cmd.accept = in_valid && sts.out_free;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec)
        else $error("execute step lasted more than one cycle");

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.exec)
        else $error("accepted transaction not executed next cycle");

    a_exec_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $past(in_valid) && $past(sts.out_free))
        else $error("execute step without an accepted transaction");
`endif

endmodule

FILE: sv/pfla_dp.sv
`timescale 1ns / 1ps

module pfla_dp #(
    parameter int PAGE_COUNT = pfla_pkg::PAGE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfla_pkg::pfla_cmd_t                 cmd,
    output pfla_pkg::pfla_sts_t                 sts,
    input  logic                                command,
    input  logic [pfla_pkg::PAGE_FIELD_W-1:0]   page_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [pfla_pkg::PAGE_FIELD_W-1:0]   result_page,
    output logic [pfla_pkg::COUNT_FIELD_W-1:0]  used_count
);
    import pfla_pkg::*;

    localparam int PAW  = $clog2(PAGE_COUNT);
    localparam int CW   = $clog2(PAGE_COUNT + 1);
    localparam int CMPW = ((CW > PAGE_FIELD_W) ? CW : PAGE_FIELD_W) + 1;
    localparam int MW   = PAW + 1;

    // Architectural state
    logic [PAW-1:0]          head_reg, head_next;
    logic [CW-1:0]           fresh_reg, fresh_next;   // first page never handed out
    logic [CW-1:0]           count_reg, count_next;

    // Latched request
    logic                    req_cmd_reg;
    logic [PAGE_FIELD_W-1:0] req_page_reg;

    // Response register
    logic                    out_valid_reg;
    pfla_status_t            out_status_reg;
    logic [PAGE_FIELD_W-1:0] out_page_reg;
    logic [COUNT_FIELD_W-1:0] out_count_reg;

    // Memory ports: entry = {in-use mark, next link}
    logic                    mem_we;
    logic [PAW-1:0]          mem_waddr;
    logic [MW-1:0]           mem_wdata;
    logic [PAW-1:0]          mem_raddr;
    logic [MW-1:0]           mem_rdata;

    logic [CMPW-1:0]         req_ext;
    logic [PAW-1:0]          req_addr;
    logic [PAW-1:0]          in_addr;
    logic                    rd_mark;
    logic [PAW-1:0]          rd_link;
    logic                    exhausted;
    logic                    fresh_hit;
    logic                    page_seen;
    logic [PAW-1:0]          head_inc;
    pfla_status_t            res_status;
    logic [PAGE_FIELD_W-1:0] res_page;

    assign in_addr   = PAW'(CMPW'(page_index));
    assign mem_raddr = (command == CMD_FREE) ? in_addr : head_reg;

    pfla_ram #(
        .WIDTH (MW),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_mark   = mem_rdata[MW-1];
    assign rd_link   = mem_rdata[PAW-1:0];
    assign req_ext   = CMPW'(req_page_reg);
    assign req_addr  = PAW'(req_ext);
    assign exhausted = (count_reg == CW'(PAGE_COUNT));
    // Head at or past the fill pointer: still on the untouched ascending chain
    assign fresh_hit = (CW'(head_reg) >= fresh_reg);
    assign head_inc  = (head_reg == PAW'(PAGE_COUNT - 1)) ? '0 : head_reg + PAW'(1);
    // Pages never handed out have a clear mark; beyond-pool pages fall out here too
    assign page_seen = (req_ext < CMPW'(fresh_reg));

    always_comb
    begin
        head_next  = head_reg;
        fresh_next = fresh_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg;
        mem_wdata  = '0;
        res_status = STATUS_IGNORED;
        res_page   = req_page_reg;
        if (req_cmd_reg == CMD_ALLOC)
        begin
            if (exhausted)
            begin
                res_status = STATUS_EXHAUSTED;
                res_page   = '0;
            end
            else
            begin
                res_status = STATUS_ALLOCATED;
                res_page   = PAGE_FIELD_W'(head_reg);
                mem_we     = cmd.exec;
                mem_waddr  = head_reg;
                mem_wdata  = {1'b1, rd_link};
                count_next = count_reg + CW'(1);
                if (fresh_hit)
                begin
                    head_next  = head_inc;
                    fresh_next = fresh_reg + CW'(1);
                end
                else
                begin
                    head_next = rd_link;
                end
            end
        end
        else if (page_seen && rd_mark)
        begin
            res_status = STATUS_FREED;
            mem_we     = cmd.exec;
            mem_waddr  = req_addr;
            mem_wdata  = {1'b0, head_reg};
            head_next  = req_addr;
            if (count_reg != '0)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                fresh_reg     <= fresh_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_cmd_reg  <= command;
            req_page_reg <= page_index;
        end
        if (cmd.exec)
        begin
            out_status_reg <= res_status;
            out_page_reg   <= res_page;
            out_count_reg  <= COUNT_FIELD_W'(count_next);
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_page  = out_page_reg;
    assign used_count   = out_count_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CW'(PAGE_COUNT))
        else $error("fill pointer ran past the pool");

    a_used_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fresh_reg)
        else $error("more pages in use than ever handed out");

    a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(head_reg) < CW'(PAGE_COUNT))
        else $error("list head outside the pool");
`endif

endmodule

FILE: sv/page_free_list_allocator.sv
// Response: out_valid is registered; it rises after the RAM read and the execute step of an accepted request.
// Requests: no new request is taken during the execute step, set by the read-then-write of the link RAM.
// Reset: rst_n is asynchronous, active low; it clears head, count, fill pointer and
// handshake state. The link RAM is not cleared: a fill pointer stands for the initial
// ascending chain and all-clear marks, so requests are taken right after reset.
`timescale 1ns / 1ps

module page_free_list_allocator #(
    parameter int PAGE_COUNT = pfla_pkg::PAGE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [pfla_pkg::PAGE_FIELD_W-1:0]   page_index,
    // Response channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [pfla_pkg::PAGE_FIELD_W-1:0]   result_page,
    output logic [pfla_pkg::COUNT_FIELD_W-1:0]  used_count
);
    import pfla_pkg::*;

    // Control group from the sequencer, status group back from the datapath
    pfla_cmd_t ctrl_cmd;
    pfla_sts_t dp_sts;

    // Sequencer: accept a transaction when the response slot will be free,
    // then apply it in the execute step once the RAM read data is back.
    pfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (ctrl_cmd)
    );

    // Datapath: list head, fill pointer, used count, link/mark RAM and the
    // response register that holds a finished result until it is taken.
    pfla_dp #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctrl_cmd),
        .sts         (dp_sts),
        .command     (command),
        .page_index  (page_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .result_page (result_page),
        .used_count  (used_count)
    );

endmodule
